// ===== hw/rtl/pip_pkg.sv =====
// Shared types and constants for the point-in-polygon crossing-number block.
// Used by the front, back, transform, top-level and testbench files; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

  localparam int COORD_W    = 24;
  localparam int ROT_W      = 16;
  localparam int COUNT_W    = 5;
  localparam int SLOT_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int FRAC_W     = 14;
  localparam int PROD_W     = COORD_W + ROT_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int RND_W      = SUM_W - FRAC_W;
  localparam int OFS_W      = RND_W + 1;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int CROSS_W    = 2 * DIFF_W;
  localparam int MIN_VERTICES = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [ROT_W-1:0]   rot_t;

  localparam coord_t COORD_MAX = 24'sh7FFFFF;
  localparam coord_t COORD_MIN = 24'sh800000;
  localparam rot_t   ROT_ONE   = 16'sd16384;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_W - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHAPE_ENABLED = 3'd0,
    REG_VERTEX_COUNT  = 3'd1,
    REG_COS_ROT       = 3'd2,
    REG_SIN_ROT       = 3'd3,
    REG_CENTER_X      = 3'd4,
    REG_CENTER_Y      = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic               shape_enabled;
    logic [COUNT_W-1:0] vertex_count;
    rot_t               cos_rot;
    rot_t               sin_rot;
    coord_t             center_x;
    coord_t             center_y;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    shape_enabled: 1'b1,
    vertex_count:  '0,
    cos_rot:       ROT_ONE,
    sin_rot:       '0,
    center_x:      '0,
    center_y:      '0
  };

  typedef struct packed {
    logic              query;
    logic              wr_en;
    logic [SLOT_W-1:0] slot;
    coord_t            x;
    coord_t            y;
  } item_t;

  typedef struct packed {
    logic valid;
    logic link;
  } tag_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pip_front.sv =====
// Front end: accepts input beats, classifies them as vertex loads or queries
// and holds them in a two-entry queue for the back end. Depends on pip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pip_front #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [pip_pkg::SLOT_W-1:0]    vertex_index,
  input  pip_pkg::coord_t               coord_x,
  input  pip_pkg::coord_t               coord_y,
  output logic                          q_valid,
  output pip_pkg::item_t                q_item,
  input  logic                          q_pop
);
  import pip_pkg::*;

  item_t             fifo_mem [QUEUE_DEPTH];
  item_t             item_in;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              push;
  logic              pop;

  assign in_stall = (fill == QCNT_W'(QUEUE_DEPTH));
  assign q_valid  = (fill != '0);
  assign q_item   = fifo_mem[rd_ptr];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_comb begin
    item_in.query = kind;
    item_in.wr_en = !kind && (32'(vertex_index) < MAX_VERTICES);
    item_in.slot  = vertex_index;
    item_in.x     = coord_x;
    item_in.y     = coord_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      fill <= fill + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= item_in;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pip_xform.sv =====
// Three-stage vertex transform: rotation by cos/sin in Q2.14, rounding,
// centre offset and saturation to 24 bits. Depends on pip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pip_xform (
  input  logic             clk,
  input  logic             rst,
  input  pip_pkg::tag_t    in_tag,
  input  pip_pkg::coord_t  lx,
  input  pip_pkg::coord_t  ly,
  input  pip_pkg::cfg_t    cfg,
  output pip_pkg::tag_t    out_tag,
  output pip_pkg::coord_t  wx,
  output pip_pkg::coord_t  wy,
  output logic             busy
);
  import pip_pkg::*;

  function automatic coord_t sat_coord(input logic signed [OFS_W-1:0] v);
    coord_t r;
    if (v > OFS_W'(COORD_MAX)) begin
      r = COORD_MAX;
    end else if (v < OFS_W'(COORD_MIN)) begin
      r = COORD_MIN;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  tag_t                      t1, t2, t3;
  logic signed [PROD_W-1:0]  p0, p1, p2, p3;
  logic signed [SUM_W-1:0]   sx, sy, rxf, ryf;
  logic signed [RND_W-1:0]   rx, ry;
  logic signed [OFS_W-1:0]   ox, oy;
  coord_t                    wx_r, wy_r;

  assign out_tag = t3;
  assign wx      = wx_r;
  assign wy      = wy_r;
  assign busy    = t1.valid | t2.valid | t3.valid;

  always_comb begin
    sx  = SUM_W'(p0) - SUM_W'(p1);
    sy  = SUM_W'(p2) + SUM_W'(p3);
    rxf = (sx + ROUND_HALF) >>> FRAC_W;
    ryf = (sy + ROUND_HALF) >>> FRAC_W;
    ox  = OFS_W'(rx) + OFS_W'(cfg.center_x);
    oy  = OFS_W'(ry) + OFS_W'(cfg.center_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1 <= '0;
      t2 <= '0;
      t3 <= '0;
    end else begin
      t1 <= in_tag;
      t2 <= t1;
      t3 <= t2;
    end
  end

  always_ff @(posedge clk) begin
    p0   <= PROD_W'(lx) * PROD_W'(cfg.cos_rot);
    p1   <= PROD_W'(ly) * PROD_W'(cfg.sin_rot);
    p2   <= PROD_W'(lx) * PROD_W'(cfg.sin_rot);
    p3   <= PROD_W'(ly) * PROD_W'(cfg.cos_rot);
    rx   <= rxf[RND_W-1:0];
    ry   <= ryf[RND_W-1:0];
    wx_r <= sat_coord(ox);
    wy_r <= sat_coord(oy);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pip_back.sv =====
// Back end: vertex store, edge walk sequencer, crossing test pipeline and
// result register. Depends on pip_pkg and pip_xform.
`timescale 1ns / 1ps
`default_nettype none

module pip_back #(
  parameter int MAX_VERTICES = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  pip_pkg::item_t  q_item,
  output logic            q_pop,
  input  pip_pkg::cfg_t   cfg,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            inside_res
);
  import pip_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);

  state_t   state, state_next;
  logic [NW-1:0] cnt, cnt_next;
  logic [NW-1:0] n_use;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          issue;
  logic          start;
  logic          emit;
  logic          acc;
  logic          flip;
  logic          pipe_busy;
  coord_t        px, py;

  coord_t        mem_x [MAX_VERTICES];
  coord_t        mem_y [MAX_VERTICES];
  tag_t          rd_tag;
  coord_t        rd_x, rd_y;

  tag_t          xf_tag;
  coord_t        wx, wy;
  logic          xf_busy;

  coord_t                    prev_x, prev_y;
  logic                      straddle;
  logic signed [DIFF_W-1:0]  dy, dpx, dxb, dpy;
  logic                      ed_v, ed_hit;
  logic signed [DIFF_W-1:0]  ed_dy, ed_dpx, ed_dxb, ed_dpy;
  logic                      ml_v, ml_hit, ml_pos;
  logic signed [CROSS_W-1:0] ml_lhs, ml_rhs;

  assign n_use = (32'(cfg.vertex_count) > MAX_VERTICES) ? NW'(MAX_VERTICES)
                                                        : NW'(cfg.vertex_count);
  assign rd_addr = (cnt == '0) ? AW'(n_use - NW'(1)) : AW'(cnt - NW'(1));
  assign wr_addr = AW'(32'(q_item.slot));
  assign pipe_busy = rd_tag.valid | xf_busy | ed_v | ml_v;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    q_pop      = 1'b0;
    issue      = 1'b0;
    start      = 1'b0;
    emit       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.query) begin
            start    = 1'b1;
            cnt_next = '0;
            if (cfg.shape_enabled && (n_use >= NW'(MIN_VERTICES))) begin
              state_next = ST_WALK;
            end else begin
              state_next = ST_EMIT;
            end
          end
        end
      end
      ST_WALK: begin
        issue    = 1'b1;
        cnt_next = cnt + NW'(1);
        if (cnt == n_use) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      acc       <= 1'b0;
      out_valid <= 1'b0;
      rd_tag    <= '0;
      ed_v      <= 1'b0;
      ml_v      <= 1'b0;
    end else begin
      state        <= state_next;
      cnt          <= cnt_next;
      rd_tag.valid <= issue;
      rd_tag.link  <= (cnt != '0);
      ed_v         <= xf_tag.valid;
      ml_v         <= ed_v;
      if (start) begin
        acc <= 1'b0;
      end else if (flip) begin
        acc <= ~acc;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      px <= q_item.x;
      py <= q_item.y;
    end
    if (emit) begin
      inside_res <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && !q_item.query && q_item.wr_en) begin
      mem_x[wr_addr] <= q_item.x;
      mem_y[wr_addr] <= q_item.y;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end

  pip_xform u_xform (
    .clk     (clk),
    .rst     (rst),
    .in_tag  (rd_tag),
    .lx      (rd_x),
    .ly      (rd_y),
    .cfg     (cfg),
    .out_tag (xf_tag),
    .wx      (wx),
    .wy      (wy),
    .busy    (xf_busy)
  );

  always_comb begin
    straddle = (wy > py) != (prev_y > py);
    dy       = DIFF_W'(prev_y) - DIFF_W'(wy);
    dpx      = DIFF_W'(px) - DIFF_W'(wx);
    dxb      = DIFF_W'(prev_x) - DIFF_W'(wx);
    dpy      = DIFF_W'(py) - DIFF_W'(wy);
    if (ml_pos) begin
      flip = ml_v && ml_hit && (ml_lhs < ml_rhs);
    end else begin
      flip = ml_v && ml_hit && (ml_lhs > ml_rhs);
    end
  end

  always_ff @(posedge clk) begin
    if (xf_tag.valid) begin
      prev_x <= wx;
      prev_y <= wy;
      ed_hit <= xf_tag.link && straddle;
      ed_dy  <= dy;
      ed_dpx <= dpx;
      ed_dxb <= dxb;
      ed_dpy <= dpy;
    end
    ml_hit <= ed_hit;
    ml_pos <= !ed_dy[DIFF_W-1];
    ml_lhs <= CROSS_W'(ed_dpx) * CROSS_W'(ed_dy);
    ml_rhs <= CROSS_W'(ed_dxb) * CROSS_W'(ed_dpy);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/point_in_polygon_crossing.sv =====
// Top level of the point-in-polygon crossing-number block: configuration
// registers, front end and back end. Depends on pip_pkg, pip_front, pip_back.
`timescale 1ns / 1ps
`default_nettype none

// Load beats (kind 0) store one local vertex; a slot at or beyond MAX_VERTICES
// is dropped. Query beats (kind 1) return one inside_res beat. For an enabled
// query over n vertices (n = vertex_count clipped to MAX_VERTICES, at least
// three) the sequencer reads one vertex a cycle from the store, n + 1 reads in
// all, and then the rotation, offset and cross-multiplication pipeline drains.
// A disabled shape or fewer than three vertices answers outside without a walk.
// A two-beat queue in front of the back end and a result register let input and
// output stall independently. Write configuration only while the block is idle.
module point_in_polygon_crossing #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pip_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pip_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            kind,
  input  logic [pip_pkg::SLOT_W-1:0]      vertex_index,
  input  pip_pkg::coord_t                 coord_x,
  input  pip_pkg::coord_t                 coord_y,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            inside_res
);
  import pip_pkg::*;

  cfg_t  cfg;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SHAPE_ENABLED: cfg.shape_enabled <= cfg_data[0];
        REG_VERTEX_COUNT:  cfg.vertex_count  <= cfg_data[COUNT_W-1:0];
        REG_COS_ROT:       cfg.cos_rot       <= cfg_data[ROT_W-1:0];
        REG_SIN_ROT:       cfg.sin_rot       <= cfg_data[ROT_W-1:0];
        REG_CENTER_X:      cfg.center_x      <= cfg_data[COORD_W-1:0];
        REG_CENTER_Y:      cfg.center_y      <= cfg_data[COORD_W-1:0];
        default:           cfg               <= cfg;
      endcase
    end
  end

  pip_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .vertex_index (vertex_index),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  pip_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .cfg        (cfg),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .inside_res (inside_res)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/pip_checker.sv =====
// Port-level checks for point_in_polygon_crossing and the bind that attaches
// them. Depends on the top level's handshake and result ports.
`timescale 1ns / 1ps
`default_nettype none

module pip_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            kind,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            inside_res
);

  logic [2:0] pending;
  logic       q_acc;
  logic       o_acc;

  assign q_acc = in_valid && !in_stall && kind;
  assign o_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(q_acc) - 3'(o_acc);
    end
  end

  a_reset_clean: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("Result valid or input stalled after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(inside_res))
    else $error("Stalled result beat changed or vanished.");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("Result beat without an outstanding query.");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd4)
    else $error("More queries outstanding than the block can hold.");

endmodule

bind point_in_polygon_crossing pip_checker u_pip_checker (.*);

`default_nettype wire

// ===== verif/point_in_polygon_crossing_test.sv =====
// Self-checking testbench for point_in_polygon_crossing: vertex loads, inside queries and
// shape settings, with each inside_res beat checked against a crossing-number predictor.
// Depends on pip_pkg and the point_in_polygon_crossing top level.
`timescale 1ns / 1ps

module point_in_polygon_crossing_test;
  import pip_pkg::*;

  localparam int MAX_VERTICES  = 16;
  localparam int SETTLE_CYCLES = MAX_VERTICES + 24;
  localparam int LIMIT         = 1000000;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  kind;
  logic [SLOT_W-1:0]     vertex_index;
  coord_t                coord_x;
  coord_t                coord_y;
  logic                  out_valid;
  logic                  out_stall;
  logic                  inside_res;

  point_in_polygon_crossing #(
    .MAX_VERTICES(MAX_VERTICES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .vertex_index(vertex_index),
    .coord_x(coord_x),
    .coord_y(coord_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .inside_res(inside_res)
  );

  // Shadow copy of the polygon store and the shape registers.
  coord_t               vert_x [MAX_VERTICES];
  coord_t               vert_y [MAX_VERTICES];
  logic                 shape_on  = CFG_RESET.shape_enabled;
  logic [COUNT_W-1:0]   count_cfg = CFG_RESET.vertex_count;
  rot_t                 cos_cfg   = CFG_RESET.cos_rot;
  rot_t                 sin_cfg   = CFG_RESET.sin_rot;
  coord_t               cx_cfg    = CFG_RESET.center_x;
  coord_t               cy_cfg    = CFG_RESET.center_y;

  bit inside_expect [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int n_items   = 0;
  int n_loads   = 0;
  int n_queries = 0;
  int n_inside  = 0;
  int n_shapes  = 0;
  int n_checked = 0;
  int n_errors  = 0;

  function automatic coord_t clamp_coord(input longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return coord_t'(v);
  endfunction

  function automatic longint scale_q14(input longint v);
    return (v + 64'sd8192) >>> FRAC_W;
  endfunction

  function automatic void world_point(input int slot, output coord_t wx, output coord_t wy);
    longint lx, ly, c, s;
    lx = longint'(vert_x[slot]);
    ly = longint'(vert_y[slot]);
    c  = longint'(cos_cfg);
    s  = longint'(sin_cfg);
    wx = clamp_coord(scale_q14(lx * c - ly * s) + longint'(cx_cfg));
    wy = clamp_coord(scale_q14(lx * s + ly * c) + longint'(cy_cfg));
  endfunction

  function automatic bit edge_crosses(input longint xa, input longint ya, input longint xb,
                                      input longint yb, input longint px, input longint py);
    longint dy, lhs, rhs;
    if ((ya > py) == (yb > py)) return 1'b0;
    dy  = yb - ya;
    lhs = (px - xa) * dy;
    rhs = (xb - xa) * (py - ya);
    if (dy > 0) return lhs < rhs;
    return lhs > rhs;
  endfunction

  function automatic bit predict_inside(input coord_t px, input coord_t py);
    coord_t wx [MAX_VERTICES];
    coord_t wy [MAX_VERTICES];
    int n, prev;
    bit in_poly;
    n = (count_cfg > MAX_VERTICES) ? MAX_VERTICES : int'(count_cfg);
    in_poly = 1'b0;
    if (!shape_on || n < MIN_VERTICES) return 1'b0;
    for (int i = 0; i < n; i++) world_point(i, wx[i], wy[i]);
    prev = n - 1;
    for (int i = 0; i < n; i++) begin
      if (edge_crosses(longint'(wx[i]), longint'(wy[i]), longint'(wx[prev]),
                       longint'(wy[prev]), longint'(px), longint'(py)))
        in_poly = ~in_poly;
      prev = i;
    end
    return in_poly;
  endfunction

  function automatic longint rand_span(input longint r);
    return longint'($urandom_range(32'(2 * r))) - r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("%0t: run did not finish within %0d cycles", $time, LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin : check_results
    bit want;
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if (!rst && out_valid && !out_stall) begin
      if (inside_expect.size() == 0) begin
        $display("%0t: unexpected inside_res beat: expected none, actual %0b", $time,
                 inside_res);
        n_errors++;
      end else begin
        want = inside_expect.pop_front();
        n_checked++;
        if (inside_res !== want) begin
          $display("%0t: inside_res mismatch: expected %0b, actual %0b", $time, want,
                   inside_res);
          n_errors++;
        end
      end
    end
  end

  task automatic send_beat(input logic k, input logic [SLOT_W-1:0] slot, input coord_t x,
                           input coord_t y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    kind         <= k;
    vertex_index <= slot;
    coord_x      <= x;
    coord_y      <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
    if (k == KIND_QUERY) begin
      inside_expect.push_back(predict_inside(x, y));
      if (inside_expect[$]) n_inside++;
      n_queries++;
    end else begin
      if (slot < MAX_VERTICES) begin
        vert_x[slot] = x;
        vert_y[slot] = y;
      end
      n_loads++;
    end
  endtask

  // Holds the sender off until every result is back and the back end has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (inside_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_SHAPE_ENABLED: shape_on  = data[0];
      REG_VERTEX_COUNT:  count_cfg = data[COUNT_W-1:0];
      REG_COS_ROT:       cos_cfg   = rot_t'(data[ROT_W-1:0]);
      REG_SIN_ROT:       sin_cfg   = rot_t'(data[ROT_W-1:0]);
      REG_CENTER_X:      cx_cfg    = coord_t'(data);
      REG_CENTER_Y:      cy_cfg    = coord_t'(data);
      default: ;
    endcase
  endtask

  // Unused bits of each write carry random values, which the block must ignore.
  task automatic program_shape(input logic en, input logic [COUNT_W-1:0] cnt, input rot_t c,
                               input rot_t s, input coord_t cx, input coord_t cy);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    d[0] = en;
    write_reg(REG_SHAPE_ENABLED, d);
    d = CFG_DATA_W'($urandom);
    d[COUNT_W-1:0] = cnt;
    write_reg(REG_VERTEX_COUNT, d);
    d = CFG_DATA_W'($urandom);
    d[ROT_W-1:0] = c;
    write_reg(REG_COS_ROT, d);
    d = CFG_DATA_W'($urandom);
    d[ROT_W-1:0] = s;
    write_reg(REG_SIN_ROT, d);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    if ($urandom_range(3) == 0)
      write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    n_shapes++;
  endtask

  task automatic test_reset_state();
    send_beat(KIND_QUERY, SLOT_W'($urandom), '0, '0);
  endtask

  task automatic test_square();
    send_beat(KIND_LOAD, SLOT_W'(0), -24'sd4096, -24'sd4096);
    send_beat(KIND_LOAD, SLOT_W'(1),  24'sd4096, -24'sd4096);
    send_beat(KIND_LOAD, SLOT_W'(2),  24'sd4096,  24'sd4096);
    send_beat(KIND_LOAD, SLOT_W'(3), -24'sd4096,  24'sd4096);
    send_beat(KIND_LOAD, SLOT_W'(4), COORD_MAX, COORD_MAX);
    send_beat(KIND_LOAD, SLOT_W'(5), COORD_MIN, COORD_MAX);
    send_beat(KIND_LOAD, SLOT_W'(6), COORD_MIN, COORD_MIN);
    send_beat(KIND_LOAD, SLOT_W'(7), COORD_MAX, COORD_MIN);
    for (int i = 8; i < MAX_VERTICES; i++)
      send_beat(KIND_LOAD, SLOT_W'(i), coord_t'(rand_span(longint'(1 << 16))),
                coord_t'(rand_span(longint'(1 << 16))));
    settle();
    program_shape(1'b1, 5'd4, ROT_ONE, '0, '0, '0);
    send_beat(KIND_QUERY, SLOT_W'(0), '0, '0);
    send_beat(KIND_QUERY, SLOT_W'(0), 24'sd8192, '0);
    send_beat(KIND_QUERY, SLOT_W'(0), -24'sd4096, -24'sd4096);
    send_beat(KIND_QUERY, SLOT_W'(0), -24'sd4096, '0);
    send_beat(KIND_QUERY, SLOT_W'(0), COORD_MAX, COORD_MIN);
  endtask

  task automatic test_special_cases();
    settle();
    program_shape(1'b0, 5'd4, ROT_ONE, '0, '0, '0);
    send_beat(KIND_QUERY, SLOT_W'(0), '0, '0);
    settle();
    program_shape(1'b1, 5'd2, ROT_ONE, '0, '0, '0);
    send_beat(KIND_QUERY, SLOT_W'(0), '0, '0);
    settle();
    program_shape(1'b1, 5'd31, ROT_ONE, '0, '0, '0);
    send_beat(KIND_QUERY, SLOT_W'(0), 24'sd100, -24'sd100);
    settle();
    program_shape(1'b1, 5'd16, '0, ROT_ONE, COORD_MAX, COORD_MIN);
    send_beat(KIND_QUERY, SLOT_W'(0), COORD_MAX - 24'sd2000, COORD_MIN + 24'sd2000);
    settle();
    program_shape(1'b1, 5'd4, -ROT_ONE, -ROT_ONE, COORD_MIN, COORD_MAX);
    send_beat(KIND_QUERY, SLOT_W'(0), COORD_MIN + 24'sd1000, COORD_MAX);
    settle();
    program_shape(1'b1, 5'd4, 16'sh8000, 16'sh7FFF, 24'sd5000, -24'sd5000);
    send_beat(KIND_QUERY, SLOT_W'(0), 24'sd5000, -24'sd5000);
  endtask

  // One shape: a setting, a run of vertex loads and a run of queries, with some
  // stray loads and queries mixed in while the polygon is half written.
  task automatic random_shape();
    int n_use, n_q, pick;
    logic en;
    logic [COUNT_W-1:0] cnt;
    rot_t c, s;
    coord_t cx, cy, qx, qy, wx, wy;
    longint span, reach;
    settle();
    en = ($urandom_range(9) != 0);
    pick = $urandom_range(9);
    if (pick == 0) cnt = COUNT_W'($urandom_range(2));
    else if (pick == 1) cnt = COUNT_W'($urandom_range(31, 17));
    else cnt = COUNT_W'($urandom_range(16, 3));
    pick = $urandom_range(9);
    if (pick < 3) begin
      case ($urandom_range(4))
        0: begin c = ROT_ONE;  s = '0;       end
        1: begin c = '0;       s = ROT_ONE;  end
        2: begin c = -ROT_ONE; s = '0;       end
        3: begin c = '0;       s = -ROT_ONE; end
        default: begin c = 16'sd11585; s = 16'sd11585; end
      endcase
    end else if (pick == 3) begin
      c = rot_t'($urandom);
      s = rot_t'($urandom);
    end else begin
      c = rot_t'(rand_span(longint'(ROT_ONE)));
      s = rot_t'(rand_span(longint'(ROT_ONE)));
    end
    span = 64'sd1 << $urandom_range(22, 4);
    reach = span + span / 2;
    if ($urandom_range(4) == 0) begin
      cx = coord_t'($urandom);
      cy = coord_t'($urandom);
    end else begin
      cx = coord_t'(rand_span(longint'(1 << 20)));
      cy = coord_t'(rand_span(longint'(1 << 20)));
    end
    program_shape(en, cnt, c, s, cx, cy);
    n_use = (cnt > MAX_VERTICES) ? MAX_VERTICES : int'(cnt);
    for (int i = 0; i < n_use; i++) begin
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(1))
          send_beat(KIND_QUERY, SLOT_W'($urandom), coord_t'($urandom), coord_t'($urandom));
        else
          send_beat(KIND_LOAD, SLOT_W'($urandom), coord_t'($urandom), coord_t'($urandom));
      end
      send_beat(KIND_LOAD, SLOT_W'(i), coord_t'(rand_span(span)), coord_t'(rand_span(span)));
    end
    n_q = $urandom_range(20, 6);
    for (int k = 0; k < n_q; k++) begin
      pick = $urandom_range(9);
      if (pick < 6 || n_use == 0) begin
        qx = clamp_coord(longint'(cx) + rand_span(reach));
        qy = clamp_coord(longint'(cy) + rand_span(reach));
      end else if (pick < 8) begin
        world_point($urandom_range(n_use - 1), wx, wy);
        qx = (pick == 6) ? wx : clamp_coord(longint'(cx) + rand_span(reach));
        qy = wy;
      end else begin
        qx = coord_t'($urandom);
        qy = coord_t'($urandom);
      end
      send_beat(KIND_QUERY, SLOT_W'($urandom), qx, qy);
    end
  endtask

  task automatic test_random_shapes(input int budget, input int send_pct, input int recv_pct);
    int stop_at;
    settle();
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    stop_at = n_items + budget;
    while (n_items < stop_at) random_shape();
  endtask

  initial begin
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    kind         <= KIND_LOAD;
    vertex_index <= '0;
    coord_x      <= '0;
    coord_y      <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct  = 10;
    recv_stall_pct = 85;

    test_reset_state();
    test_square();
    test_special_cases();
    test_random_shapes(370, 10, 85);
    test_random_shapes(370, 85, 10);
    test_random_shapes(370, 0, 0);
    settle();

    $display("Covered %0d vertex loads and %0d queries (%0d inside) over %0d shape settings.",
             n_loads, n_queries, n_inside, n_shapes);
    $display("Checked %0d result beats, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/pip_pkg.sv
hw/rtl/pip_front.sv
hw/rtl/pip_xform.sv
hw/rtl/pip_back.sv
hw/rtl/point_in_polygon_crossing.sv
hw/rtl/pip_checker.sv
verif/point_in_polygon_crossing_test.sv
